@@ design/polar_force_feedback_mapper_defines.svh @@
// ----------------------------------------------------------------------------
// Polar force feedback mapper assertion macros
// Shared assertion wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef POLAR_FORCE_FEEDBACK_MAPPER_DEFINES_SVH
`define POLAR_FORCE_FEEDBACK_MAPPER_DEFINES_SVH

// checked only out of reset
`define PFFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define PFFM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/pffm_pkg.sv @@
// ----------------------------------------------------------------------------
// Polar force feedback mapper package
// Widths, constants, arctangent table and stage record types.
// ----------------------------------------------------------------------------
package pffm_pkg;

  localparam int DW      = 16;
  localparam int LIMIT_W = 15;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10240;

  // word index of the force limit register
  localparam logic REG_FORCE_LIMIT = 1'b0;

  localparam int PIPE_DEPTH = 16;

  // root search: two result bits per stage
  localparam int ROOT_STEPS     = 16;
  localparam int ROOT_PER_STAGE = 2;
  localparam int ROOT_STAGES    = ROOT_STEPS / ROOT_PER_STAGE;
  localparam int ROOT_REM_W     = 64;
  localparam int ROOT_DEN_W     = 32;
  localparam int ROOT_P_W       = 48;

  // vectoring CORDIC: two rotations per stage
  localparam int CORDIC_STEPS     = 24;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CW               = 36;
  localparam int ZW               = 28;

  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;

  localparam logic [18:0]        COEF_RADIAL = 19'd352846;
  localparam logic signed [16:0] COEF_ANGLE  = 17'sd46504;
  localparam logic signed [19:0] COEF_HEIGHT = 20'sd257556;
  localparam logic signed [23:0] OFF_RADIAL  = 24'sd2867;
  localparam logic signed [23:0] OFF_ANGLE   = 24'sd4538;
  localparam logic signed [23:0] OFF_HEIGHT  = 24'sd2212;

  typedef struct packed {
    logic [DW-1:0]         m;
    logic [ROOT_P_W-1:0]   p;
    logic [ROOT_REM_W-1:0] rem;
    logic [ROOT_DEN_W-1:0] den;
  } root_st_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic                 x_neg;
    logic                 y_neg;
  } cordic_st_t;

  typedef struct packed {
    logic                 nx_neg;
    logic                 ny_neg;
    logic                 zero;
    logic signed [DW-1:0] jh;
    logic signed [DW-1:0] fx;
    logic signed [DW-1:0] fy;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 28'sd13176795;
      1:  a = 28'sd7778716;
      2:  a = 28'sd4110060;
      3:  a = 28'sd2086331;
      4:  a = 28'sd1047214;
      5:  a = 28'sd524117;
      6:  a = 28'sd262123;
      7:  a = 28'sd131069;
      8:  a = 28'sd65536;
      9:  a = 28'sd32768;
      10: a = 28'sd16384;
      11: a = 28'sd8192;
      12: a = 28'sd4096;
      13: a = 28'sd2048;
      14: a = 28'sd1024;
      15: a = 28'sd512;
      16: a = 28'sd256;
      17: a = 28'sd128;
      18: a = 28'sd64;
      19: a = 28'sd32;
      20: a = 28'sd16;
      21: a = 28'sd8;
      22: a = 28'sd4;
      23: a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ design/pffm_root.sv @@
// ----------------------------------------------------------------------------
// Pipelined root search
// Largest m with m*m*den <= rem, two result bits per stage, no multiplier.
// ----------------------------------------------------------------------------
module pffm_root import pffm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ROOT_REM_W-1:0] rem_i,
  input  logic [ROOT_DEN_W-1:0] den_i,
  output logic [DW-1:0]         root_o,
  output logic [ROOT_REM_W-1:0] rem_o
);

  root_st_t st_in [ROOT_STAGES];
  root_st_t st_d  [ROOT_STAGES];
  root_st_t st_q  [ROOT_STAGES];

  assign st_in[0] = '{m: '0, p: '0, rem: rem_i, den: den_i};

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign st_in[s] = st_q[s-1];
    end

    // p tracks m*den; trial cost is (2m*b + b*b)*den
    always_comb begin : step
      root_st_t                cur;
      logic [ROOT_REM_W+1:0]   dd;
      int                      k;
      cur = st_in[s];
      for (int j = 0; j < ROOT_PER_STAGE; j++) begin
        k  = ROOT_STEPS - 1 - (s * ROOT_PER_STAGE + j);
        dd = ((ROOT_REM_W+2)'(cur.p) << (k + 1)) + ((ROOT_REM_W+2)'(cur.den) << (2 * k));
        if ({2'b00, cur.rem} >= dd) begin
          cur.rem = cur.rem - dd[ROOT_REM_W-1:0];
          cur.m   = cur.m | (DW'(1) << k);
          cur.p   = cur.p + (ROOT_P_W'(cur.den) << k);
        end
      end
      st_d[s] = cur;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign root_o = st_q[ROOT_STAGES-1].m;
  assign rem_o  = st_q[ROOT_STAGES-1].rem;

endmodule

@@ design/pffm_cordic.sv @@
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// Drives (|x|, |y|) onto the x axis and sums the Q.24 arctangent steps.
// ----------------------------------------------------------------------------
module pffm_cordic import pffm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] pos_x_i,
  input  logic signed [DW-1:0] pos_y_i,
  output logic signed [ZW-1:0] z_o,
  output logic                 x_neg_o,
  output logic                 y_neg_o
);

  cordic_st_t init_d, init_q;
  cordic_st_t st_in [CORDIC_STAGES];
  cordic_st_t st_d  [CORDIC_STAGES];
  cordic_st_t st_q  [CORDIC_STAGES];

  always_comb begin
    logic signed [DW:0] ax, ay;
    ax = pos_x_i[DW-1] ? -(DW+1)'(pos_x_i) : (DW+1)'(pos_x_i);
    ay = pos_y_i[DW-1] ? -(DW+1)'(pos_y_i) : (DW+1)'(pos_y_i);
    init_d.cx    = CW'(ax) <<< 16;
    init_d.cy    = CW'(ay) <<< 16;
    init_d.z     = '0;
    init_d.x_neg = pos_x_i[DW-1];
    init_d.y_neg = pos_y_i[DW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      init_q <= init_d;
    end
  end

  assign st_in[0] = init_q;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign st_in[s] = st_q[s-1];
    end

    // cy == 0 leaves everything alone
    always_comb begin : step
      logic signed [CW-1:0] cx, cy, tx, ty;
      logic signed [ZW-1:0] z;
      int                   i;
      cx = st_in[s].cx;
      cy = st_in[s].cy;
      z  = st_in[s].z;
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        i  = s * CORDIC_PER_STAGE + j;
        tx = cx >>> i;
        ty = cy >>> i;
        if (cy > 0) begin
          cx = cx + ty;
          cy = cy - tx;
          z  = z + atan_q24(i);
        end else if (cy < 0) begin
          cx = cx - ty;
          cy = cy + tx;
          z  = z - atan_q24(i);
        end
      end
      st_d[s]    = st_in[s];
      st_d[s].cx = cx;
      st_d[s].cy = cy;
      st_d[s].z  = z;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign z_o     = st_q[CORDIC_STAGES-1].z;
  assign x_neg_o = st_q[CORDIC_STAGES-1].x_neg;
  assign y_neg_o = st_q[CORDIC_STAGES-1].y_neg;

endmodule

@@ design/polar_force_feedback_mapper.sv @@
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// Depth is set by the 16-step root searches (two bits a stage) and the
// 24-step angle CORDIC (two rotations a stage), run side by side.
// Reset clears every valid bit and sets force_limit to 2.5 (10240).
// ----------------------------------------------------------------------------
// Polar force feedback mapper
// Radius, angle, rotated and clamped feedback and joint targets per item.
// ----------------------------------------------------------------------------
module polar_force_feedback_mapper import pffm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [DW-1:0] force_x_i,
  input  logic signed [DW-1:0] force_y_i,
  input  logic signed [DW-1:0] force_z_i,
  input  logic signed [DW-1:0] pos_x_i,
  input  logic signed [DW-1:0] pos_y_i,
  input  logic signed [DW-1:0] pos_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DW-1:0] feedback_x_o,
  output logic signed [DW-1:0] feedback_y_o,
  output logic signed [DW-1:0] feedback_z_o,
  output logic [DW-1:0]        radius_o,
  output logic signed [DW-1:0] angle_o,
  output logic signed [DW-1:0] joint_radial_o,
  output logic signed [DW-1:0] joint_angle_o,
  output logic signed [DW-1:0] joint_height_o,
  output logic signed [DW-1:0] joint_radial_neg_o
);

  function automatic logic signed [DW-1:0] sat16(input logic signed [23:0] v);
    logic signed [DW-1:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] clamp_lim(input logic signed [DW:0] v,
                                                     input logic [LIMIT_W-1:0] lim);
    logic signed [DW:0]   l;
    logic signed [DW-1:0] r;
    l = (DW+1)'({2'b00, lim});
    if (v > l) begin
      r = l[DW-1:0];
    end else if (v < -l) begin
      r = DW'(-l);
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] fb_of(input logic [DW-1:0] m, input logic neg,
                                                 input logic [LIMIT_W-1:0] lim);
    logic [LIMIT_W-1:0] mc;
    mc = (m > {1'b0, lim}) ? lim : m[LIMIT_W-1:0];
    return neg ? -DW'(mc) : DW'(mc);
  endfunction

  // ---------------- configuration ----------------
  logic [LIMIT_W-1:0] limit_q;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FORCE_LIMIT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FORCE_LIMIT) ? PDATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic [PIPE_DEPTH-1:0] v_q;
  logic                  en;

  assign en          = !(v_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: products ----------------
  logic        [31:0] s1_pxx_q, s1_pyy_q;
  logic signed [31:0] s1_fxpy_q, s1_fypx_q, s1_fxpx_q, s1_fypy_q;
  logic signed [35:0] s1_hp_q;
  logic signed [DW-1:0] s1_fx_q, s1_fy_q;
  logic signed [31:0] pxx, pyy;

  assign pxx = 32'(pos_x_i) * 32'(pos_x_i);
  assign pyy = 32'(pos_y_i) * 32'(pos_y_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pxx_q  <= unsigned'(pxx);
      s1_pyy_q  <= unsigned'(pyy);
      s1_fxpy_q <= 32'(force_x_i) * 32'(pos_y_i);
      s1_fypx_q <= 32'(force_y_i) * 32'(pos_x_i);
      s1_fxpx_q <= 32'(force_x_i) * 32'(pos_x_i);
      s1_fypy_q <= 32'(force_y_i) * 32'(pos_y_i);
      s1_hp_q   <= 36'(pos_z_i) * 36'(COEF_HEIGHT);
      s1_fx_q   <= force_x_i;
      s1_fy_q   <= force_y_i;
    end
  end

  // ---------------- stage 2: sums ----------------
  logic        [31:0] s2_s2_q;
  logic signed [33:0] s2_nx_q, s2_ny_q;
  logic signed [DW-1:0] s2_jh_q, s2_fx_q, s2_fy_q;
  logic signed [35:0] hp_rnd;
  logic signed [23:0] jh_w;

  assign hp_rnd = s1_hp_q + 36'sd32768;
  assign jh_w   = 24'(hp_rnd >>> 16) - OFF_HEIGHT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s2_q <= s1_pxx_q + s1_pyy_q;
      s2_nx_q <= 34'(s1_fxpy_q) + (34'(s1_fypx_q) <<< 1);
      s2_ny_q <= 34'(s1_fxpx_q) - (34'(s1_fypy_q) <<< 1);
      s2_jh_q <= sat16(jh_w);
      s2_fx_q <= s1_fx_q;
      s2_fy_q <= s1_fy_q;
    end
  end

  // ---------------- stage 3: magnitudes ----------------
  logic        [31:0] s3_s2_q, s3_nxa_q, s3_nya_q;
  logic               s3_nxn_q, s3_nyn_q;
  logic signed [DW-1:0] s3_jh_q, s3_fx_q, s3_fy_q;
  logic signed [33:0] nx_abs, ny_abs;

  assign nx_abs = s2_nx_q[33] ? -s2_nx_q : s2_nx_q;
  assign ny_abs = s2_ny_q[33] ? -s2_ny_q : s2_ny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_s2_q  <= s2_s2_q;
      s3_nxa_q <= nx_abs[31:0];
      s3_nya_q <= ny_abs[31:0];
      s3_nxn_q <= s2_nx_q[33];
      s3_nyn_q <= s2_ny_q[33];
      s3_jh_q  <= s2_jh_q;
      s3_fx_q  <= s2_fx_q;
      s3_fy_q  <= s2_fy_q;
    end
  end

  // ---------------- stage 4: squares ----------------
  logic [63:0] s4_nx2_q, s4_ny2_q;
  logic [31:0] s4_s2_q;
  side_t       s4_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_nx2_q         <= 64'(s3_nxa_q) * 64'(s3_nxa_q);
      s4_ny2_q         <= 64'(s3_nya_q) * 64'(s3_nya_q);
      s4_s2_q          <= s3_s2_q;
      s4_side_q.nx_neg <= s3_nxn_q;
      s4_side_q.ny_neg <= s3_nyn_q;
      s4_side_q.zero   <= (s3_s2_q == '0);
      s4_side_q.jh     <= s3_jh_q;
      s4_side_q.fx     <= s3_fx_q;
      s4_side_q.fy     <= s3_fy_q;
    end
  end

  // ---------------- stages 5 to 12: root searches ----------------
  logic [DW-1:0]         fbx_m, fby_m, rad_m;
  logic [ROOT_REM_W-1:0] fbx_rem, fby_rem, rad_rem;
  side_t                 side_q [ROOT_STAGES];

  // |N|/sqrt(s2) truncated is the largest m with m*m*s2 <= N*N
  pffm_root u_root_fbx (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (s4_nx2_q),
    .den_i (s4_s2_q),
    .root_o(fbx_m),
    .rem_o (fbx_rem)
  );

  pffm_root u_root_fby (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (s4_ny2_q),
    .den_i (s4_s2_q),
    .root_o(fby_m),
    .rem_o (fby_rem)
  );

  pffm_root u_root_rad (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (ROOT_REM_W'(s4_s2_q)),
    .den_i (ROOT_DEN_W'(1)),
    .root_o(rad_m),
    .rem_o (rad_rem)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s4_side_q;
      for (int i = 1; i < ROOT_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------- angle CORDIC, result at stage 13 ----------------
  logic signed [ZW-1:0] cz;
  logic                 cx_neg, cy_neg;

  pffm_cordic u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .z_o    (cz),
    .x_neg_o(cx_neg),
    .y_neg_o(cy_neg)
  );

  // ---------------- stage 13: radius rounding, feedback ----------------
  logic [DW-1:0]        s13_r_q;
  logic signed [DW-1:0] s13_fbx_q, s13_fby_q, s13_jh_q;
  side_t                sd;
  logic signed [DW-1:0] fbx_d, fby_d;

  assign sd = side_q[ROOT_STAGES-1];

  always_comb begin
    if (sd.zero) begin
      // origin: sin 0, cos 1
      fbx_d = clamp_lim((DW+1)'(sd.fy) <<< 1, limit_q);
      fby_d = clamp_lim((DW+1)'(sd.fx), limit_q);
    end else begin
      fbx_d = fb_of(fbx_m, sd.nx_neg, limit_q);
      fby_d = fb_of(fby_m, sd.ny_neg, limit_q);
    end
  end

  // fbx_rem and fby_rem are not needed past the search
  logic unused_rem;
  assign unused_rem = ^{fbx_rem, fby_rem};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s13_r_q   <= rad_m + DW'(rad_rem > ROOT_REM_W'(rad_m));
      s13_fbx_q <= fbx_d;
      s13_fby_q <= fby_d;
      s13_jh_q  <= sd.jh;
    end
  end

  // ---------------- stage 14: angle finish, radial product ----------------
  logic signed [DW-1:0] s14_ang_q, s14_fbx_q, s14_fby_q, s14_jh_q;
  logic [DW-1:0]        s14_r_q;
  logic [35:0]          s14_rp_q;
  logic signed [ZW-1:0] zc, zr;
  logic signed [DW-1:0] ang_d;

  always_comb begin
    zc = (cz < 0) ? '0 : cz;
    if (cx_neg) begin
      zc = PI_Q24 - zc;
    end
    zr    = (zc + ZW'(1024)) >>> 11;
    ang_d = cy_neg ? -zr[DW-1:0] : zr[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s14_ang_q <= ang_d;
      s14_rp_q  <= 36'(s13_r_q) * 36'(COEF_RADIAL);
      s14_r_q   <= s13_r_q;
      s14_fbx_q <= s13_fbx_q;
      s14_fby_q <= s13_fby_q;
      s14_jh_q  <= s13_jh_q;
    end
  end

  // ---------------- stage 15: angle product, radial joints ----------------
  logic signed [32:0]   s15_ap_q;
  logic signed [DW-1:0] s15_ang_q, s15_fbx_q, s15_fby_q, s15_jh_q, s15_jr_q, s15_jn_q;
  logic [DW-1:0]        s15_r_q;
  logic [35:0]          rp_rnd;
  logic signed [23:0]   jr_w;

  assign rp_rnd = s14_rp_q + 36'd32768;
  assign jr_w   = signed'(24'(rp_rnd >> 16)) - OFF_RADIAL;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s15_ap_q  <= 33'(s14_ang_q) * 33'(COEF_ANGLE);
      s15_jr_q  <= sat16(jr_w);
      s15_jn_q  <= sat16(-jr_w);
      s15_ang_q <= s14_ang_q;
      s15_r_q   <= s14_r_q;
      s15_fbx_q <= s14_fbx_q;
      s15_fby_q <= s14_fby_q;
      s15_jh_q  <= s14_jh_q;
    end
  end

  // ---------------- stage 16: output register ----------------
  logic signed [32:0] ap_rnd;
  logic signed [23:0] ja_w;

  assign ap_rnd = s15_ap_q + 33'sd65536;
  assign ja_w   = 24'(ap_rnd >>> 17) - OFF_ANGLE;

  always_ff @(posedge clk_i) begin
    if (en) begin
      feedback_x_o       <= s15_fbx_q;
      feedback_y_o       <= s15_fby_q;
      radius_o           <= s15_r_q;
      angle_o            <= s15_ang_q;
      joint_radial_o     <= s15_jr_q;
      joint_angle_o      <= sat16(ja_w);
      joint_height_o     <= s15_jh_q;
      joint_radial_neg_o <= s15_jn_q;
    end
  end

  assign feedback_z_o = '0;

  // force_z is carried on the port but plays no part
  logic unused_fz;
  assign unused_fz = ^{force_z_i, paddr[1:0], pwdata[PDATA_W-1:LIMIT_W], unused_rem};

endmodule

@@ design/pffm_checker.sv @@
// ----------------------------------------------------------------------------
// Polar force feedback mapper port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "polar_force_feedback_mapper_defines.svh"

module pffm_checker import pffm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [DW-1:0] feedback_x_o,
  input logic signed [DW-1:0] feedback_z_o,
  input logic [DW-1:0]        radius_o,
  input logic signed [DW-1:0] angle_o
);

  // input side backs up exactly when a finished item is held
  `PFFM_ASSERT(a_stall_link, (in_stall_o == (out_valid_o && out_stall_i)), "stall link broken")

  `PFFM_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(radius_o) && $stable(angle_o) && $stable(feedback_x_o)), "held item changed")

  `PFFM_ASSERT(a_fz_zero, out_valid_o |-> (feedback_z_o == 16'sd0), "feedback z not zero")

  `PFFM_ASSERT(a_polar_range, out_valid_o |-> ((radius_o <= 16'd46341) && (angle_o <= 16'sd25736) && (angle_o >= -16'sd25736)), "polar result out of range")

  // valid bits are only known clear once a reset edge has been seen
  `PFFM_ASSERT_RST(a_reset_empty, (!rst_ni && $past(!rst_ni)) |-> (!out_valid_o), "item shown in reset")

endmodule

bind polar_force_feedback_mapper pffm_checker u_pffm_checker (.*);
